// ----- hw/rtl/quadratic_probe_hash_set_defines.svh -----
// assertion macros for the hash set
`ifndef QUADRATIC_PROBE_HASH_SET_DEFINES_SVH
`define QUADRATIC_PROBE_HASH_SET_DEFINES_SVH
`ifndef SYNTH
`define QPHS_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define QPHS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define QPHS_ASSERT(lbl, cond)
`define QPHS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- hw/rtl/qphs_pkg.sv -----
package qphs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int EFF_W       = $clog2(TABLE_DEPTH + 1);
    localparam int SIZE_W      = 11;
    localparam int KEY_W       = 32;
    localparam int OUT_W       = 2;
    localparam int CNT_W       = $clog2(KEY_W);

    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    localparam logic [OUT_W-1:0] OC_INSERTED  = 2'd0;
    localparam logic [OUT_W-1:0] OC_DROPPED   = 2'd1;
    localparam logic [OUT_W-1:0] OC_FOUND     = 2'd2;
    localparam logic [OUT_W-1:0] OC_NOT_FOUND = 2'd3;

    localparam logic REG_TABLE_SIZE = 1'b0;

    typedef struct packed {
        logic             action;
        logic [KEY_W-1:0] key;
        logic [IDX_W-1:0] home;
    } req_t;

    typedef struct packed {
        logic valid;
        req_t req;
    } link_t;

endpackage

// ----- hw/rtl/quadratic_probe_hash_set.sv -----
// open-addressed set of signed 32-bit keys with quadratic probing. each request
// inserts or searches a key and yields one outcome. after reset the slot memory
// is swept empty, one slot a cycle, with full held high. the front computes key
// mod size with a bit-serial divider, taking no new request until its division
// is done, and hands the home slot through a two-entry queue; the back reads and
// then checks one slot per probe on the single-port slot memory. front and back
// overlap, so the front can divide a new key while the back still probes an
// earlier one. table_size sits at byte address 0 and is to be written only while
// the block is idle; the block itself does not enforce this
module quadratic_probe_hash_set (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          push,
    output logic                          full,
    input  logic                          action,
    input  logic signed [qphs_pkg::KEY_W-1:0] key,
    output logic                          empty,
    input  logic                          pop,
    output logic [qphs_pkg::OUT_W-1:0]    outcome
);
    import qphs_pkg::*;

    logic [SIZE_W-1:0] table_size_reg;
    logic [EFF_W-1:0]  size_eff;
    logic              clearing;
    logic              front_full;
    link_t             link;
    logic              link_pop;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TABLE_SIZE) ? {{(32 - SIZE_W){1'b0}}, table_size_reg}
                                                 : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg <= SIZE_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_TABLE_SIZE))
        begin
            table_size_reg <= pwdata[SIZE_W-1:0];
        end
    end

    always_comb
    begin
        if (32'(table_size_reg) > 32'(TABLE_DEPTH))
        begin
            size_eff = EFF_W'(TABLE_DEPTH);
        end
        else if (table_size_reg == '0)
        begin
            size_eff = EFF_W'(1);
        end
        else
        begin
            size_eff = EFF_W'(table_size_reg);
        end
    end

    qphs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .clearing (clearing),
        .size_eff (size_eff),
        .push     (push),
        .full     (front_full),
        .action   (action),
        .key      (key),
        .link     (link),
        .link_pop (link_pop)
    );

    qphs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .size_eff (size_eff),
        .clearing (clearing),
        .link     (link),
        .link_pop (link_pop),
        .empty    (empty),
        .pop      (pop),
        .outcome  (outcome)
    );

    assign full = front_full;

endmodule

// ----- hw/rtl/qphs_ram.sv -----
module qphs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/qphs_front.sv -----
module qphs_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  clearing,
    input  logic [qphs_pkg::EFF_W-1:0] size_eff,
    input  logic                  push,
    output logic                  full,
    input  logic                  action,
    input  logic [qphs_pkg::KEY_W-1:0] key,
    output qphs_pkg::link_t       link,
    input  logic                  link_pop
);
    import qphs_pkg::*;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } fstate_t;

    fstate_t          state_reg, state_next;
    logic             act_reg;
    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] mag_reg;
    logic [EFF_W-1:0] rem_reg;
    logic [CNT_W-1:0] bit_cnt_reg;
    logic             neg_reg;

    logic [EFF_W:0]   trial;
    logic [EFF_W:0]   trial_sub;
    logic [EFF_W-1:0] home_full;
    req_t             new_req;
    logic             accept;
    logic             q_push;

    req_t       q_mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] q_cnt_reg;

    assign accept = (state_reg == F_IDLE) && push && !clearing;
    assign full   = (state_reg != F_IDLE) || clearing;
    assign q_push = (state_reg == F_PUSH) && (q_cnt_reg != 2'd2);

    // restoring division of the key magnitude, one bit a cycle
    assign trial     = {rem_reg, mag_reg[KEY_W-1]};
    assign trial_sub = trial - {1'b0, size_eff};

    assign home_full = (neg_reg && (rem_reg != '0)) ? (size_eff - rem_reg) : rem_reg;

    always_comb
    begin
        new_req.action = act_reg;
        new_req.key    = key_reg;
        new_req.home   = home_full[IDX_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = F_DIV;
                end
            end
            F_DIV:
            begin
                if (bit_cnt_reg == CNT_W'(KEY_W - 1))
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (q_push)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            q_cnt_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (link_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            q_cnt_reg <= q_cnt_reg + {1'b0, q_push} - {1'b0, link_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg     <= action;
            key_reg     <= key;
            neg_reg     <= key[KEY_W-1];
            mag_reg     <= key[KEY_W-1] ? (~key + 1'b1) : key;
            rem_reg     <= '0;
            bit_cnt_reg <= '0;
        end
        else if (state_reg == F_DIV)
        begin
            mag_reg     <= {mag_reg[KEY_W-2:0], 1'b0};
            rem_reg     <= trial_sub[EFF_W] ? trial[EFF_W-1:0] : trial_sub[EFF_W-1:0];
            bit_cnt_reg <= bit_cnt_reg + 1'b1;
        end
        if (q_push)
        begin
            q_mem_reg[wr_ptr_reg] <= new_req;
        end
    end

    assign link.valid = (q_cnt_reg != 2'd0);
    assign link.req   = q_mem_reg[rd_ptr_reg];

endmodule

// ----- hw/rtl/qphs_back.sv -----
`include "quadratic_probe_hash_set_defines.svh"

module qphs_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [qphs_pkg::EFF_W-1:0] size_eff,
    output logic                  clearing,
    input  qphs_pkg::link_t       link,
    output logic                  link_pop,
    output logic                  empty,
    input  logic                  pop,
    output logic [qphs_pkg::OUT_W-1:0] outcome
);
    import qphs_pkg::*;

    typedef enum logic [3:0] {
        B_CLEAR = 4'b0001,
        B_IDLE  = 4'b0010,
        B_READ  = 4'b0100,
        B_CHECK = 4'b1000
    } bstate_t;

    bstate_t          state_reg, state_next;
    logic [IDX_W-1:0] clr_idx_reg;
    logic             act_reg;
    logic [KEY_W-1:0] key_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [EFF_W-1:0] step_reg;
    logic [EFF_W-1:0] probe_cnt_reg;

    logic             ram_we;
    logic [IDX_W-1:0] ram_addr;
    logic [KEY_W:0]   ram_wdata;
    logic [KEY_W:0]   ram_rdata;

    logic             slot_used;
    logic             done;
    logic [OUT_W-1:0] done_code;
    logic             last_probe;
    logic [EFF_W:0]   idx_sum;
    logic [EFF_W:0]   idx_red;
    logic [EFF_W:0]   step_sum;
    logic [EFF_W:0]   step_red;

    logic [OUT_W-1:0] res_mem_reg [2];
    logic             res_wr_reg;
    logic             res_rd_reg;
    logic [1:0]       res_cnt_reg;
    logic             res_pop;

    qphs_ram #(
        .WIDTH (KEY_W + 1),
        .DEPTH (TABLE_DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign clearing   = (state_reg == B_CLEAR);
    assign link_pop   = (state_reg == B_IDLE) && link.valid && (res_cnt_reg != 2'd2);
    assign slot_used  = ram_rdata[KEY_W];
    assign last_probe = ((probe_cnt_reg + 1'b1) == size_eff);

    // next probe: idx += 2i+1 and step += 2, both kept below the size
    assign idx_sum  = {1'b0, {(EFF_W - IDX_W){1'b0}}, idx_reg} + {1'b0, step_reg};
    assign idx_red  = (idx_sum >= {1'b0, size_eff}) ? (idx_sum - {1'b0, size_eff}) : idx_sum;
    assign step_sum = {1'b0, step_reg} + (EFF_W + 1)'(2);
    assign step_red = (step_sum >= {1'b0, size_eff}) ? (step_sum - {1'b0, size_eff})
                                                     : step_sum;

    always_comb
    begin
        done      = 1'b0;
        done_code = OC_NOT_FOUND;
        if (state_reg == B_CHECK)
        begin
            if (act_reg == ACT_INSERT)
            begin
                if (!slot_used)
                begin
                    done      = 1'b1;
                    done_code = OC_INSERTED;
                end
                else if (last_probe)
                begin
                    done      = 1'b1;
                    done_code = OC_DROPPED;
                end
            end
            else
            begin
                if (!slot_used)
                begin
                    done      = 1'b1;
                    done_code = OC_NOT_FOUND;
                end
                else if (ram_rdata[KEY_W-1:0] == key_reg)
                begin
                    done      = 1'b1;
                    done_code = OC_FOUND;
                end
                else if (last_probe)
                begin
                    done      = 1'b1;
                    done_code = OC_NOT_FOUND;
                end
            end
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = idx_reg;
        ram_wdata = {1'b1, key_reg};
        if (state_reg == B_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_addr  = clr_idx_reg;
            ram_wdata = '0;
        end
        else if ((state_reg == B_CHECK) && (act_reg == ACT_INSERT) && !slot_used)
        begin
            ram_we = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_CLEAR:
            begin
                if (clr_idx_reg == IDX_W'(TABLE_DEPTH - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (link_pop)
                begin
                    state_next = B_READ;
                end
            end
            B_READ:
            begin
                state_next = B_CHECK;
            end
            B_CHECK:
            begin
                state_next = done ? B_IDLE : B_READ;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign res_pop = pop && (res_cnt_reg != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_CLEAR;
            clr_idx_reg <= '0;
            res_wr_reg  <= 1'b0;
            res_rd_reg  <= 1'b0;
            res_cnt_reg <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (done)
            begin
                res_wr_reg <= !res_wr_reg;
            end
            if (res_pop)
            begin
                res_rd_reg <= !res_rd_reg;
            end
            res_cnt_reg <= res_cnt_reg + {1'b0, done} - {1'b0, res_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_pop)
        begin
            act_reg       <= link.req.action;
            key_reg       <= link.req.key;
            idx_reg       <= link.req.home;
            step_reg      <= (size_eff > EFF_W'(1)) ? EFF_W'(1) : '0;
            probe_cnt_reg <= '0;
        end
        else if ((state_reg == B_CHECK) && !done)
        begin
            idx_reg       <= idx_red[IDX_W-1:0];
            step_reg      <= step_red[EFF_W-1:0];
            probe_cnt_reg <= probe_cnt_reg + 1'b1;
        end
        if (done)
        begin
            res_mem_reg[res_wr_reg] <= done_code;
        end
    end

    assign empty   = (res_cnt_reg == 2'd0);
    assign outcome = res_mem_reg[res_rd_reg];

    `QPHS_ASSERT(a_res_cnt, res_cnt_reg != 2'd3)
    `QPHS_ASSERT_NEXT(a_read_check, state_reg == B_READ, state_reg == B_CHECK)
    `QPHS_ASSERT(a_pop_valid, !link_pop || link.valid)
    `QPHS_ASSERT(a_idx_range, (state_reg != B_READ) || (EFF_W'(idx_reg) < size_eff))

endmodule

// ----- test/qphs_checker.sv -----
`timescale 1ns / 100ps
module qphs_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        push,
    input  logic        full,
    input  logic        action,
    input  logic [31:0] key,
    input  logic        empty,
    input  logic        pop,
    input  logic [1:0]  outcome,
    output int          fail_count,
    output int          pending,
    output int          seen_outcomes [4]
);
    import qphs_pkg::*;

    logic [KEY_W-1:0]  set_keys [TABLE_DEPTH];
    logic              set_used [TABLE_DEPTH];
    logic [SIZE_W-1:0] size_reg;
    logic [OUT_W-1:0]  outcome_queue [$];

    function automatic int live_size();
        int s;
        s = size_reg;
        if (s < 1) s = 1;
        if (s > TABLE_DEPTH) s = TABLE_DEPTH;
        return s;
    endfunction

    function automatic logic [OUT_W-1:0] apply_request(logic act, logic [KEY_W-1:0] k);
        longint s;
        longint home;
        longint idx;
        s = live_size();
        home = longint'(signed'(k)) % s;
        if (home < 0) home += s;
        for (longint i = 0; i < s; i++)
        begin
            idx = (home + i * i) % s;
            if (!set_used[idx])
            begin
                if (act == ACT_INSERT)
                begin
                    set_used[idx] = 1'b1;
                    set_keys[idx] = k;
                    return OC_INSERTED;
                end
                return OC_NOT_FOUND;
            end
            if (act == ACT_SEARCH && set_keys[idx] == k)
                return OC_FOUND;
        end
        return (act == ACT_INSERT) ? OC_DROPPED : OC_NOT_FOUND;
    endfunction

    task automatic report(string what);
        $display("mismatch at %0t: %s", $time, what);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        pending = 0;
        for (int i = 0; i < 4; i++) seen_outcomes[i] = 0;
        for (int i = 0; i < TABLE_DEPTH; i++) set_used[i] = 1'b0;
        size_reg = SIZE_RESET;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_TABLE_SIZE)
                size_reg = pwdata[SIZE_W-1:0];
            if (push && !full)
                outcome_queue.push_back(apply_request(action, key));
            if (pop && !empty)
            begin
                seen_outcomes[outcome]++;
                if (outcome_queue.size() == 0)
                    report($sformatf("outcome %0d with no request waiting", outcome));
                else
                begin
                    if (outcome !== outcome_queue[0])
                        report($sformatf("outcome %0d, predicted %0d", outcome,
                                         outcome_queue[0]));
                    void'(outcome_queue.pop_front());
                end
            end
            pending = outcome_queue.size();
        end
    end
endmodule

// ----- test/tb_quadratic_probe_hash_set.sv -----
`timescale 1ns / 100ps
module tb_quadratic_probe_hash_set;
    import qphs_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        push;
    logic        full;
    logic        action;
    logic signed [KEY_W-1:0] key;
    logic        empty;
    logic        pop;
    logic [OUT_W-1:0] outcome;
    int          fail_count;
    int          pending;
    int          seen_outcomes [4];
    int          hold_off;
    bit          calm;
    int          sent;
    logic [KEY_W-1:0] recent_keys [$];

    quadratic_probe_hash_set dut (.*);

    qphs_checker checker_i (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .push, .full, .action, .key(key), .empty, .pop, .outcome,
        .fail_count, .pending, .seen_outcomes
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    initial
    begin
        #200ms;
        $display("timeout");
        $display("Regression FAIL");
        $finish;
    end

    // result side: random pops, a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            pop <= 1'b0;
        end
        else
            pop <= calm ? 1'b1 : ($urandom_range(99) >= 15);
    end

    task automatic write_size(int value);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 3'd0; pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // push stays high after an accepted request until the next call or drain
    task automatic send_request(logic act, logic [KEY_W-1:0] k);
        while (!calm && $urandom_range(99) < 15)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1; action <= act; key <= k;
        @(posedge clk);
        while (full) @(posedge clk);
        sent++;
        if (act == ACT_INSERT)
        begin
            recent_keys.push_back(k);
            if (recent_keys.size() > 64) void'(recent_keys.pop_front());
        end
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key(int span);
        int r;
        r = $urandom_range(9);
        if (r < 3 && recent_keys.size() > 0)
            return recent_keys[$urandom_range(recent_keys.size() - 1)];
        if (r < 5)
            return $urandom;
        if (r < 6)
            return -$urandom_range(span);
        return $urandom_range(span);
    endfunction

    task automatic random_phase(int count, int span);
        for (int n = 0; n < count; n++)
            send_request(1'($urandom_range(1)), pick_key(span));
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        push = 1'b0; action = ACT_INSERT; key = '0;
        hold_off = 0; calm = 1'b0; sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed requests at reset size, extremes and former sentinel keys
        send_request(ACT_SEARCH, 32'sd5);
        send_request(ACT_INSERT, 32'h7FFF_FFFF);
        send_request(ACT_INSERT, 32'h8000_0000);
        send_request(ACT_INSERT, -32'sd1);
        send_request(ACT_INSERT, -32'sd2);
        send_request(ACT_SEARCH, -32'sd1);
        send_request(ACT_SEARCH, -32'sd2);
        send_request(ACT_SEARCH, 32'h7FFF_FFFF);
        send_request(ACT_SEARCH, 32'h8000_0000);
        send_request(ACT_INSERT, 32'sd1024);
        send_request(ACT_INSERT, 32'sd0);
        send_request(ACT_SEARCH, 32'sd2048);
        send_request(ACT_INSERT, 32'sd0);
        send_request(ACT_SEARCH, 32'sd0);
        drain();

        // size zero acts as one: slot 0 is held from before, so both inserts drop
        write_size(0);
        send_request(ACT_INSERT, 32'sd9);
        send_request(ACT_INSERT, 32'sd3);
        send_request(ACT_SEARCH, 32'sd9);
        send_request(ACT_SEARCH, 32'sd3);
        drain();

        // oversize saturates; old contents visible again
        write_size(2047);
        send_request(ACT_SEARCH, 32'h7FFF_FFFF);
        send_request(ACT_SEARCH, 32'sd1024);
        drain();

        // fill a small table until it drops, stall the result side meanwhile
        write_size(7);
        hold_off <= 300;
        random_phase(40, 50);
        drain();

        write_size(1);
        random_phase(30, 20);
        drain();

        write_size(37);
        random_phase(300, 200);
        drain();

        write_size(16);
        calm = 1'b1;
        random_phase(200, 100);
        calm = 1'b0;
        drain();

        write_size(1024);
        random_phase(900, 100000);
        drain();

        write_size(513);
        random_phase(400, 5000);
        drain();

        $display("%0d requests: %0d inserted, %0d dropped, %0d found, %0d not found",
                 sent, seen_outcomes[0], seen_outcomes[1], seen_outcomes[2],
                 seen_outcomes[3]);
        $display("table sizes 0, 1, 7, 16, 37, 513, 1024 and 2047 were used");
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
